FILE: rtl/core/cst_pkg.sv
// cst_pkg: shared types and constants for the column score top-k block.
// Used by column_score_top_k and its port checker; depends on nothing.
`timescale 1ns / 1ps

package cst_pkg;

  // Fixed field widths
  localparam int unsigned COL_W     = 6;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned OUT_CNT_W = 16;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned MAX_COLS  = 64;

  // Configuration register indexes
  localparam logic [0:0] CFG_TOP_COUNT   = 1'b0;
  localparam logic [0:0] CFG_COLS_IN_USE = 1'b1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] TOP_COUNT_RST   = 7'd10;
  localparam logic [CFG_W-1:0] COLS_IN_USE_RST = 7'd64;

  // Item modes
  localparam logic MODE_CELL   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } cst_state_e;

endpackage

FILE: rtl/core/column_score_top_k.sv
// Throughput: a cell transaction is taken every cycle while idle (cells leave busy
//   low); its accumulator update is registered in the accumulate stage, then written
//   to memory, with forwarding between cells. A finish transaction sets busy; each
//   rank scans the ncols accumulators through the single memory read port, one
//   column per cycle, and gives one result at the end of its scan.
// Reset: config goes to top_count=10, columns_in_use=64; per-column valid bits clear,
//   so every accumulator reads as zero; no clearing pass. Results cannot be stalled.
`timescale 1ns / 1ps

module column_score_top_k
  import cst_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // command channel
  input  logic                    start,
  output logic                    busy,
  input  logic                    mode_i,
  input  logic [COL_W-1:0]        column_i,
  input  logic signed [VAL_W-1:0] cell_value_i,
  input  logic                    row_end_i,
  // configuration channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [0:0]              cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  // result channel
  output logic                    strobe_o,
  output logic [COL_W-1:0]        rank_o,
  output logic [COL_W-1:0]        best_column_o,
  output logic [OUT_CNT_W-1:0]    positive_count_o,
  output logic [SUM_W-1:0]        value_sum_o,
  output logic [OUT_CNT_W-1:0]    rows_seen_o,
  output logic                    last_o
);

  localparam int unsigned DEPTH  = (NUM_COLUMNS < MAX_COLS) ? NUM_COLUMNS : MAX_COLS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned ENT_W  = COUNT_WIDTH + SUM_W;
  localparam logic [CFG_W-1:0] DEPTH_C = CFG_W'(DEPTH);

  // State and control
  cst_state_e               state_q, state_d;
  logic [CFG_W-1:0]         top_q, cols_q;
  logic [CFG_W-1:0]         ncols, ntop;
  logic [COUNT_WIDTH-1:0]   row_cnt_q;

  // Memory and read stage
  logic [ENT_W-1:0]         mem_q [DEPTH];
  logic [ENT_W-1:0]         rd_data_q;
  logic [DEPTH-1:0]         vld_q;
  logic                     rd_vld_q;
  logic [AW-1:0]            rd_addr;
  logic [COUNT_WIDTH-1:0]   rd_cnt;
  logic [SUM_W-1:0]         rd_sum;

  // Accumulate stage
  logic                     s1_valid_q;
  logic [AW-1:0]            s1_addr_q;
  logic [VAL_W-2:0]         s1_val_q;
  logic                     fwd_q;
  logic [COUNT_WIDTH-1:0]   byp_cnt_q;
  logic [SUM_W-1:0]         byp_sum_q;
  logic [COUNT_WIDTH-1:0]   op_cnt, cnt_new;
  logic [SUM_W-1:0]         op_sum, sum_new;
  logic [SUM_W:0]           sum_ext;

  // Scan stage
  logic [AW:0]              scan_col_q;
  logic                     chk_q;
  logic [AW-1:0]            chk_col_q;
  logic                     found_q;
  logic [AW-1:0]            best_col_q;
  logic [COUNT_WIDTH-1:0]   best_cnt_q;
  logic [SUM_W-1:0]         best_sum_q;
  logic [CFG_W-1:0]         rank_q;
  logic [DEPTH-1:0]         emit_q;

  // Decoded controls
  logic                     accept, accept_cell, accept_finish;
  logic                     cell_hit, in_range, positive;
  logic                     scan_issue, scan_done, take, last_rank;

  // Clip the configuration to the usable ranges
  always_comb begin
    ncols = cols_q;
    if (ncols > DEPTH_C) ncols = DEPTH_C;
    if (ncols == '0) ncols = CFG_W'(1);
    ntop = top_q;
    if (ntop > ncols) ntop = ncols;
    if (ntop == '0) ntop = CFG_W'(1);
  end

  // Decode the transaction
  assign busy          = (state_q != ST_IDLE);
  assign cfg_ready_o   = ~busy;
  assign accept        = start & ~busy;
  assign accept_cell   = accept & (mode_i == MODE_CELL);
  assign accept_finish = accept & (mode_i == MODE_FINISH);
  assign in_range      = ({1'b0, column_i} < DEPTH_C);
  assign positive      = (cell_value_i > 0);
  assign cell_hit      = accept_cell & in_range & positive;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_finish) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done && last_rank) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Scan controls
  always_comb begin
    scan_issue = 1'b0;
    scan_done  = 1'b0;
    rd_addr    = column_i[AW-1:0];
    case (state_q)
      ST_SCAN: begin
        rd_addr    = scan_col_q[AW-1:0];
        scan_issue = (CFG_W'(scan_col_q) < ncols);
        scan_done  = ~scan_issue & ~chk_q;
      end
      default: begin
        rd_addr = column_i[AW-1:0];
      end
    endcase
  end

  assign last_rank = ((rank_q + CFG_W'(1)) == ntop);
  assign rd_cnt    = rd_data_q[ENT_W-1:SUM_W];
  assign rd_sum    = rd_data_q[SUM_W-1:0];

  // Pick the better column: higher sum, then higher count, lower index on ties
  always_comb begin
    take = 1'b0;
    if (chk_q && !emit_q[chk_col_q]) begin
      if (!found_q) take = 1'b1;
      else if (op_sum > best_sum_q) take = 1'b1;
      else if (op_sum == best_sum_q && op_cnt > best_cnt_q) take = 1'b1;
    end
  end

  // Operand: forwarded update, stored entry, or zero for an unwritten entry
  always_comb begin
    if (fwd_q) begin
      op_cnt = byp_cnt_q;
      op_sum = byp_sum_q;
    end else if (rd_vld_q) begin
      op_cnt = rd_cnt;
      op_sum = rd_sum;
    end else begin
      op_cnt = '0;
      op_sum = '0;
    end
  end

  // Saturating updates
  assign sum_ext = {1'b0, op_sum} + (SUM_W+1)'(s1_val_q);
  assign sum_new = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign cnt_new = (op_cnt == '1) ? op_cnt : op_cnt + COUNT_WIDTH'(1);

  // Accumulator memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) mem_q[s1_addr_q] <= {cnt_new, sum_new};
    rd_data_q <= mem_q[rd_addr];
  end

  // Hold the accumulate stage payload and the bypass copy
  always_ff @(posedge clk_i) begin
    s1_addr_q <= column_i[AW-1:0];
    s1_val_q  <= cell_value_i[VAL_W-2:0];
    byp_cnt_q <= cnt_new;
    byp_sum_q <= sum_new;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      top_q      <= TOP_COUNT_RST;
      cols_q     <= COLS_IN_USE_RST;
      row_cnt_q  <= '0;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      scan_col_q <= '0;
      chk_q      <= 1'b0;
      found_q    <= 1'b0;
      rank_q     <= '0;
      emit_q     <= '0;
      strobe_o   <= 1'b0;
    end else begin
      state_q    <= state_d;
      strobe_o   <= 1'b0;
      rd_vld_q   <= vld_q[rd_addr];
      s1_valid_q <= cell_hit;
      fwd_q      <= accept_cell & s1_valid_q & (s1_addr_q == column_i[AW-1:0]);

      // configuration write
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_TOP_COUNT:   top_q  <= cfg_data_i;
          CFG_COLS_IN_USE: cols_q <= cfg_data_i;
          default: ;
        endcase
      end

      // mark written entries
      if (s1_valid_q) vld_q[s1_addr_q] <= 1'b1;

      // count rows
      if (accept_cell && row_end_i && row_cnt_q != '1) row_cnt_q <= row_cnt_q + COUNT_WIDTH'(1);

      // start a ranking run
      if (accept_finish) begin
        scan_col_q <= '0;
        chk_q      <= 1'b0;
        found_q    <= 1'b0;
        rank_q     <= '0;
        emit_q     <= '0;
      end

      // advance the scan
      if (state_q == ST_SCAN) begin
        chk_q <= scan_issue;
        if (scan_issue) scan_col_q <= scan_col_q + (AW+1)'(1);
        if (take) found_q <= 1'b1;
        if (scan_done) begin
          strobe_o         <= 1'b1;
          emit_q[best_col_q] <= 1'b1;
          rank_q           <= rank_q + CFG_W'(1);
          scan_col_q       <= '0;
          found_q          <= 1'b0;
          if (last_rank) begin
            vld_q     <= '0;
            emit_q    <= '0;
            row_cnt_q <= '0;
          end
        end
      end
    end
  end

  // Track the best candidate and drive the result
  always_ff @(posedge clk_i) begin
    chk_col_q <= scan_col_q[AW-1:0];
    if (take) begin
      best_col_q <= chk_col_q;
      best_cnt_q <= op_cnt;
      best_sum_q <= op_sum;
    end
    if (state_q == ST_SCAN && scan_done) begin
      rank_o           <= rank_q[COL_W-1:0];
      best_column_o    <= COL_W'(best_col_q);
      positive_count_o <= OUT_CNT_W'(best_cnt_q);
      value_sum_o      <= best_sum_q;
      rows_seen_o      <= OUT_CNT_W'(row_cnt_q);
      last_o           <= last_rank;
    end
  end

endmodule

FILE: rtl/core/cst_checker.sv
// cst_checker: port-level checks on the column score top-k block over time.
// Depends on cst_pkg; bound to column_score_top_k at the end of this file.
`timescale 1ns / 1ps

module cst_checker
  import cst_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic mode_i,
  input logic strobe_o,
  input logic last_o
);

  // A finish transaction starts a ranking run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_FINISH) |=> busy)
    else $error("finish transaction did not raise busy");

  // Cell transactions never stall the command channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_CELL) |=> !busy)
    else $error("cell transaction raised busy");

  // Results before the last one come while the run is still busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> busy)
    else $error("non-final result outside a ranking run");

  // Results are never strobed back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("results on consecutive cycles");

endmodule

bind column_score_top_k cst_checker u_cst_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .mode_i   (mode_i),
  .strobe_o (strobe_o),
  .last_o   (last_o)
);
